### hdl/connection_expiry_queue_assert.svh
// Assertion helpers for the expiry queue RTL
`ifndef CONNECTION_EXPIRY_QUEUE_ASSERT_SVH
`define CONNECTION_EXPIRY_QUEUE_ASSERT_SVH

// plain property, checked every cycle outside reset
`define CEXQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// implication, checked every cycle outside reset
`define CEXQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

### hdl/cexq_pkg.sv
// ----------------------------------------------------------------------------
// cexq_pkg
// Types and codes shared by the connection expiry queue modules.
// ----------------------------------------------------------------------------
package cexq_pkg;

  localparam logic [1:0] KIND_TOUCH = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_KILL  = 2'd2;
  localparam logic [1:0] KIND_KALL  = 2'd3;

  localparam logic [1:0] CAUSE_DEADLINE = 2'd0;
  localparam logic [1:0] CAUSE_KILL     = 2'd1;
  localparam logic [1:0] CAUSE_KALL     = 2'd2;

  localparam int unsigned SLOT_W = 5;
  localparam int unsigned TMO_W  = 16;
  localparam int unsigned TIME_W = 32;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic              keep_flag;
  } cexq_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] expired_slot;
    logic [1:0]        cause;
    logic              last;
  } cexq_out_t;

endpackage

### hdl/cexq_ram.sv
// ----------------------------------------------------------------------------
// cexq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cexq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/cexq_fifo.sv
// ----------------------------------------------------------------------------
// cexq_fifo
// Small flop-based queue, first-word fall-through, power-of-two depth.
// ----------------------------------------------------------------------------
module cexq_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW:0]      wp_r, wp_nxt;
  logic [AW:0]      rp_r, rp_nxt;
  logic             do_push, do_pop;

  assign full    = (wp_r[AW] != rp_r[AW]) && (wp_r[AW-1:0] == rp_r[AW-1:0]);
  assign empty   = (wp_r == rp_r);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r[AW-1:0]];
  assign wp_nxt  = wp_r + (AW+1)'(do_push);
  assign rp_nxt  = rp_r + (AW+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r[AW-1:0]] <= wdata;
    end
  end

endmodule

### hdl/cexq_front.sv
// ----------------------------------------------------------------------------
// cexq_front
// Input side: takes items, drops touch/kill of slots out of range, and
// queues the rest for the list sequencer.
// ----------------------------------------------------------------------------
module cexq_front #(
  parameter int unsigned SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  cexq_pkg::cexq_in_t in_data,
  output logic               cmd_vld,
  output cexq_pkg::cexq_in_t cmd,
  input  logic               cmd_pop
);
  import cexq_pkg::*;

  localparam int unsigned CMD_DEPTH = 2;

  logic drop;
  logic cmd_empty;
  logic [$bits(cexq_in_t)-1:0] cmd_bits;

  // tick and kill-all never carry a slot, so only touch and kill are checked
  assign drop = (in_data.kind == KIND_TOUCH || in_data.kind == KIND_KILL) &&
                ({2'b00, in_data.slot} >= 7'(SLOTS));

  cexq_fifo #(
    .WIDTH ($bits(cexq_in_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !drop),
    .wdata (in_data),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd     = cexq_in_t'(cmd_bits);
  assign cmd_vld = !cmd_empty;

endmodule

### hdl/cexq_back.sv
// ----------------------------------------------------------------------------
// cexq_back
// List sequencer: owns the epoch counter, the linked list in RAM and the
// per-slot linked bits; performs touch, tick, kill and kill-all.
// ----------------------------------------------------------------------------
module cexq_back #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cexq_pkg::TMO_W-1:0]  cfg_wdata,
  input  logic                        cmd_vld,
  input  cexq_pkg::cexq_in_t          cmd,
  output logic                        cmd_pop,
  output logic                        oq_push,
  output cexq_pkg::cexq_out_t         oq_data,
  input  logic                        oq_full
);
  import cexq_pkg::*;

  localparam int unsigned SIDX_W = $clog2(SLOTS);
  localparam int unsigned LNK_W  = SIDX_W + 1;
  localparam logic [LNK_W-1:0] NONE = {LNK_W{1'b1}};

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_UNL  = 8'b0000_0010,
    S_APP  = 8'b0000_0100,
    S_APP2 = 8'b0000_1000,
    S_EMIT = 8'b0001_0000,
    S_HEAD = 8'b0010_0000,
    S_CHK  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [SIDX_W-1:0]   s_r, s_nxt;
  logic [SIDX_W-1:0]   h_r, h_nxt;
  logic [TIME_W-1:0]   now_r, now_nxt;
  logic [TMO_W-1:0]    tmo_r;
  logic [LNK_W-1:0]    first_r, first_nxt;
  logic [LNK_W-1:0]    last_r, last_nxt;
  logic [SLOTS-1:0]    linked_r, linked_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [SIDX_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [1:0]          pend_cause_r, pend_cause_nxt;

  logic [SIDX_W-1:0]   cs;
  logic [SIDX_W-1:0]   raddr;
  logic                dl_we, dl_re, nx_we, nx_re, pv_we, pv_re;
  logic [SIDX_W-1:0]   dl_waddr, nx_waddr, pv_waddr;
  logic [TIME_W-1:0]   dl_wdata, dl_rd;
  logic [LNK_W-1:0]    nx_wdata, pv_wdata, nx_rd, pv_rd;

  assign cs = SIDX_W'(cmd.slot);

  cexq_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_dl_ram (
    .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .re(dl_re), .raddr(raddr), .rdata(dl_rd)
  );

  cexq_ram #(.WIDTH(LNK_W), .DEPTH(SLOTS)) u_nx_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .re(nx_re), .raddr(raddr), .rdata(nx_rd)
  );

  cexq_ram #(.WIDTH(LNK_W), .DEPTH(SLOTS)) u_pv_ram (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .re(pv_re), .raddr(raddr), .rdata(pv_rd)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    s_nxt          = s_r;
    h_nxt          = h_r;
    now_nxt        = now_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    linked_nxt     = linked_r;
    pend_vld_nxt   = pend_vld_r;
    pend_slot_nxt  = pend_slot_r;
    pend_cause_nxt = pend_cause_r;
    cmd_pop        = 1'b0;
    oq_push        = 1'b0;
    oq_data        = '0;
    raddr          = s_r;
    dl_we = 1'b0; dl_re = 1'b0; nx_we = 1'b0; nx_re = 1'b0;
    pv_we = 1'b0; pv_re = 1'b0;
    dl_waddr = s_r; nx_waddr = s_r; pv_waddr = s_r;
    dl_wdata = now_r; nx_wdata = NONE; pv_wdata = NONE;

    case (state_r)
      S_IDLE: begin
        if (cmd_vld) begin
          cmd_pop = 1'b1;
          op_nxt  = cmd.kind;
          s_nxt   = cs;
          raddr   = cs;
          case (cmd.kind)
            KIND_TOUCH: begin
              dl_we    = 1'b1;
              dl_waddr = cs;
              dl_wdata = cmd.keep_flag ? now_r + TIME_W'(tmo_r) : now_r;
              if (linked_r[cs]) begin
                nx_re     = 1'b1;
                pv_re     = 1'b1;
                state_nxt = S_UNL;
              end else begin
                state_nxt = S_APP;
              end
            end
            KIND_TICK: begin
              now_nxt   = now_r + 1'b1;
              state_nxt = S_HEAD;
            end
            KIND_KILL: begin
              if (linked_r[cs]) begin
                nx_re     = 1'b1;
                pv_re     = 1'b1;
                state_nxt = S_UNL;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            default: state_nxt = S_HEAD;
          endcase
        end
      end
      S_UNL: begin
        // pv_rd / nx_rd are the neighbors of s_r
        if (!pv_rd[LNK_W-1]) begin
          nx_we    = 1'b1;
          nx_waddr = pv_rd[SIDX_W-1:0];
          nx_wdata = nx_rd;
        end else begin
          first_nxt = nx_rd;
        end
        if (!nx_rd[LNK_W-1]) begin
          pv_we    = 1'b1;
          pv_waddr = nx_rd[SIDX_W-1:0];
          pv_wdata = pv_rd;
        end else begin
          last_nxt = pv_rd;
        end
        linked_nxt[s_r] = 1'b0;
        state_nxt = (op_r == KIND_TOUCH) ? S_APP : S_EMIT;
      end
      S_APP: begin
        if (!last_r[LNK_W-1]) begin
          nx_we    = 1'b1;
          nx_waddr = last_r[SIDX_W-1:0];
          nx_wdata = LNK_W'(s_r);
        end else begin
          first_nxt = LNK_W'(s_r);
        end
        pv_we    = 1'b1;
        pv_wdata = last_r;
        last_nxt = LNK_W'(s_r);
        linked_nxt[s_r] = 1'b1;
        state_nxt = S_APP2;
      end
      S_APP2: begin
        nx_we     = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EMIT: begin
        if (!oq_full) begin
          oq_push   = 1'b1;
          oq_data   = '{expired_slot: SLOT_W'(s_r), cause: CAUSE_KILL, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_HEAD: begin
        if (first_r[LNK_W-1]) begin
          if (op_r == KIND_TICK) begin
            now_nxt = '0;
          end
          state_nxt = S_FIN;
        end else begin
          raddr     = first_r[SIDX_W-1:0];
          dl_re     = 1'b1;
          nx_re     = 1'b1;
          h_nxt     = first_r[SIDX_W-1:0];
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (op_r == KIND_TICK && dl_rd > now_r) begin
          state_nxt = S_FIN;
        end else if (!pend_vld_r || !oq_full) begin
          // the previous removal is known not to be the last one
          if (pend_vld_r) begin
            oq_push = 1'b1;
            oq_data = '{expired_slot: SLOT_W'(pend_slot_r), cause: pend_cause_r,
                        last: 1'b0};
          end
          first_nxt = nx_rd;
          if (!nx_rd[LNK_W-1]) begin
            pv_we    = 1'b1;
            pv_waddr = nx_rd[SIDX_W-1:0];
            pv_wdata = NONE;
          end else begin
            last_nxt = NONE;
          end
          linked_nxt[h_r] = 1'b0;
          pend_vld_nxt    = 1'b1;
          pend_slot_nxt   = h_r;
          pend_cause_nxt  = (op_r == KIND_TICK) ? CAUSE_DEADLINE : CAUSE_KALL;
          state_nxt       = S_HEAD;
        end
      end
      S_FIN: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (!oq_full) begin
          oq_push      = 1'b1;
          oq_data      = '{expired_slot: SLOT_W'(pend_slot_r), cause: pend_cause_r,
                           last: 1'b1};
          pend_vld_nxt = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      now_r      <= '0;
      first_r    <= NONE;
      last_r     <= NONE;
      linked_r   <= '0;
      pend_vld_r <= 1'b0;
      tmo_r      <= TMO_W'(15);
    end else begin
      state_r    <= state_nxt;
      now_r      <= now_nxt;
      first_r    <= first_nxt;
      last_r     <= last_nxt;
      linked_r   <= linked_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (cfg_we) begin
        tmo_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    s_r          <= s_nxt;
    h_r          <= h_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_cause_r <= pend_cause_nxt;
  end

`include "connection_expiry_queue_assert.svh"

  `CEXQ_ASSERT(a_ends_agree, clk, rst_n, first_r[LNK_W-1] == last_r[LNK_W-1])
  `CEXQ_ASSERT_IMP(a_empty_unlinked, clk, rst_n, first_r[LNK_W-1], linked_r == '0)
  `CEXQ_ASSERT_IMP(a_idle_no_pend, clk, rst_n, state_r == S_IDLE, !pend_vld_r)
  `CEXQ_ASSERT_IMP(a_pop_only_idle, clk, rst_n, cmd_pop, state_r == S_IDLE && cmd_vld)

endmodule

### hdl/connection_expiry_queue.sv
// ----------------------------------------------------------------------------
// connection_expiry_queue
// Expiry list of connection slots ordered by last activity, with an epoch
// counter; reports slots removed by tick deadline, kill and kill-all.
// Sequence: a kill passes S_UNL if the slot is linked, then S_EMIT; a touch
//   passes S_UNL if linked, then S_APP and S_APP2; tick and kill-all loop
//   S_HEAD and S_CHK per removed slot, and the last report leaves in S_FIN.
// Throughput: one item in the sequencer at a time; RAM reads are registered.
// Reset: synchronous active-low rst_n empties the list, clears now and
//   sets the idle timeout to 15; no clearing pass is needed.
// ----------------------------------------------------------------------------
module connection_expiry_queue #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  cexq_pkg::cexq_in_t          in_data,
  output logic                        out_empty,
  input  logic                        out_pop,
  output cexq_pkg::cexq_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [cexq_pkg::TMO_W-1:0]  cfg_wdata
);
  import cexq_pkg::*;

  localparam int unsigned OUT_DEPTH = 4;

  cexq_in_t  cmd;
  logic      cmd_vld, cmd_pop;
  logic      oq_push, oq_full;
  cexq_out_t oq_data;
  logic [$bits(cexq_out_t)-1:0] out_bits;

  cexq_front #(.SLOTS(SLOTS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .cmd_vld (cmd_vld),
    .cmd     (cmd),
    .cmd_pop (cmd_pop)
  );

  cexq_back #(.SLOTS(SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_vld   (cmd_vld),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .oq_push   (oq_push),
    .oq_data   (oq_data),
    .oq_full   (oq_full)
  );

  cexq_fifo #(
    .WIDTH ($bits(cexq_out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_data),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (out_bits),
    .empty (out_empty)
  );

  assign out_data = cexq_out_t'(out_bits);

endmodule
